/* design/b32e_pkg.sv */
`timescale 1ns / 1ps
package b32e_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SYM_W       = 7;
    localparam int unsigned FIELD_W     = 5;
    localparam int unsigned TAIL_W      = 4;
    localparam int unsigned GROUP_W     = 3 * BYTE_W;
    localparam int unsigned NUM_FIELDS  = 5;
    localparam int unsigned IDX_W       = $clog2(NUM_FIELDS);
    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 8;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [SYM_W-1:0] PAD_SYM     = 7'd61;
    localparam logic [SYM_W-1:0] LETTER_BASE = 7'd64;
    localparam logic [SYM_W-1:0] DIGIT_BASE  = 7'd23;
    localparam logic [FIELD_W-1:0] LAST_LETTER = 5'd26;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FIELDS - 1);

    typedef struct packed {
        logic               last;
        logic [GROUP_W-1:0] bits;
    } t_group;

    function automatic logic [SYM_W-1:0] to_symbol(input logic [FIELD_W-1:0] v);
        logic [SYM_W-1:0] s;
        if (v == '0) begin
            s = PAD_SYM;
        end else if (v <= LAST_LETTER) begin
            s = LETTER_BASE + SYM_W'(v);
        end else begin
            s = DIGIT_BASE + SYM_W'(v);
        end
        return s;
    endfunction

endpackage

/* design/b32e_front.sv */
`timescale 1ns / 1ps
module b32e_front
    import b32e_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_end,
    output logic              o_push,
    output t_group            o_group
);

    logic [BYTE_W-1:0] r_held0, r_held1;
    logic [1:0]        r_count;
    logic              hold;

    assign hold   = !i_end && (r_count < 2'd2);
    assign o_push = i_accept && !hold;

    always_comb begin
        o_group.last = i_end;
        unique case (r_count)
            2'd0:    o_group.bits = {i_byte, {BYTE_W{1'b0}}, {BYTE_W{1'b0}}};
            2'd1:    o_group.bits = {r_held0, i_byte, {BYTE_W{1'b0}}};
            default: o_group.bits = {r_held0, r_held1, i_byte};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_held0 <= '0;
            r_held1 <= '0;
        end else if (i_accept) begin
            if (hold) begin
                r_count <= r_count + 2'd1;
                if (r_count == 2'd0) begin
                    r_held0 <= i_byte;
                end else begin
                    r_held1 <= i_byte;
                end
            end else begin
                r_count <= 2'd0;
                r_held0 <= '0;
                r_held1 <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("byte count out of range");
`endif

endmodule

/* design/b32e_queue.sv */
`timescale 1ns / 1ps
module b32e_queue
    import b32e_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_group
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_group = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* design/b32e_back.sv */
`timescale 1ns / 1ps
module b32e_back
    import b32e_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_group           i_group,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [SYM_W-1:0] o_symbol,
    output logic             o_group_last,
    output logic             o_message_last
);

    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [GROUP_W-1:0] r_bits;
    logic               r_last;
    logic [FIELD_W-1:0] field;
    logic               at_end;

    assign at_end = (r_idx == IDX_LAST);
    assign o_pop  = !i_q_empty && (!r_busy || (i_ready && at_end));

    always_comb begin
        unique case (r_idx)
            3'd0:    field = r_bits[23:19];
            3'd1:    field = r_bits[18:14];
            3'd2:    field = r_bits[13:9];
            3'd3:    field = r_bits[8:4];
            default: field = {1'b0, r_bits[TAIL_W-1:0]};
        endcase
    end

    assign o_valid        = r_busy;
    assign o_symbol       = to_symbol(field);
    assign o_group_last   = at_end;
    assign o_message_last = at_end && r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_group.bits;
            r_last <= i_group.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (at_end) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("symbol index out of range");
    a_msg_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_message_last |-> o_group_last)
        else $error("message end off group end");
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |-> !o_pop)
        else $error("group loaded over a stalled one");
`endif

endmodule

/* design/byte_to_base32_symbol_encoder.sv */
`timescale 1ns / 1ps
// A group's first symbol follows its queue write and its load into back end registers.
// One byte per cycle in while the group queue has room; one symbol per cycle out while
// the receiver is ready, five symbols per group, set by the back end emitting the symbols.
// The group queue (QUEUE_DEPTH entries) lets input bytes keep flowing while symbols drain.
// Reset (synchronous, active low) drops held bytes, empties the queue, idles the output.
module byte_to_base32_symbol_encoder
    import b32e_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,  // [7:0] data_byte
    input  logic                   i_s_tlast,  // message_end
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,  // [6:0] symbol, [7] zero
    output logic                   o_m_tuser,  // [0] group_last
    output logic                   o_m_tlast   // message_last
);

    logic             q_full, q_empty, push, pop, accept;
    t_group           front_group, q_group;
    logic [SYM_W-1:0] symbol;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    b32e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_s_tdata[BYTE_W-1:0]),
        .i_end   (i_s_tlast),
        .o_push  (push),
        .o_group (front_group)
    );

    b32e_queue #(
        .DEPTH(QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_group(front_group),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_group(q_group)
    );

    b32e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_group       (q_group),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_symbol      (symbol),
        .o_group_last  (o_m_tuser),
        .o_message_last(o_m_tlast)
    );

    assign o_m_tdata = {{(TDATA_OUT_W - SYM_W){1'b0}}, symbol};

endmodule

/* sim/byte_to_base32_symbol_encoder_chk.sv */
`timescale 1ns / 1ps
module byte_to_base32_symbol_encoder_chk
    import b32e_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,  // [7:0] data_byte
    input  logic                   i_s_tlast,  // message_end
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [TDATA_OUT_W-1:0] i_m_tdata,  // [6:0] symbol, [7] zero
    input  logic                   i_m_tuser,  // [0] group_last
    input  logic                   i_m_tlast,  // message_last
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [7:0] ASC_PAD     = "=";
    localparam logic [7:0] ASC_A       = "A";
    localparam logic [7:0] ASC_2       = "2";
    localparam int         NUM_LETTERS = 26;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             group_last;
        logic             message_last;
    } t_symbol_word;

    t_symbol_word      expected_symbols[$];
    logic [BYTE_W-1:0] held_bytes [2];
    logic [1:0]        held_count;
    int                fails = 0;

    function automatic logic [SYM_W-1:0] field_to_ascii(input logic [FIELD_W-1:0] v);
        logic [7:0] c;
        if (v == '0) begin
            c = ASC_PAD;
        end else if (v <= NUM_LETTERS) begin
            c = ASC_A + 8'(v) - 8'd1;
        end else begin
            c = ASC_2 + 8'(v) - 8'(NUM_LETTERS + 1);
        end
        return c[SYM_W-1:0];
    endfunction

    // hold the byte, or close the group and queue its five symbols
    task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        logic [GROUP_W-1:0] group;
        logic [FIELD_W-1:0] field;
        int                 k;
        if (!msg_end && held_count < 2) begin
            held_bytes[held_count[0]] = b;
            held_count = held_count + 2'd1;
        end else begin
            case (held_count)
                2'd0: begin
                    group = {b, 16'h0000};
                end
                2'd1: begin
                    group = {held_bytes[0], b, 8'h00};
                end
                default: begin
                    group = {held_bytes[0], held_bytes[1], b};
                end
            endcase
            for (k = 0; k < NUM_FIELDS; k++) begin
                if (k == NUM_FIELDS - 1) begin
                    field = FIELD_W'(group[TAIL_W-1:0]);
                end else begin
                    field = group[GROUP_W-1-FIELD_W*k -: FIELD_W];
                end
                expected_symbols.push_back('{field_to_ascii(field),
                                             k == NUM_FIELDS - 1,
                                             (k == NUM_FIELDS - 1) && msg_end});
            end
            held_bytes[0] = '0;
            held_bytes[1] = '0;
            held_count    = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_symbol_word want;
        if (!i_rst_n) begin
            held_bytes[0] = '0;
            held_bytes[1] = '0;
            held_count    = '0;
            expected_symbols.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                encode_byte(i_s_tdata[BYTE_W-1:0], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_symbols.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%b tlast=%b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_m_tdata !== {{(TDATA_OUT_W-SYM_W){1'b0}}, want.symbol}) begin
                        fails++;
                        $display("%0t: symbol mismatch, expected %h, actual %h",
                                 $time, want.symbol, i_m_tdata);
                    end
                    if (i_m_tuser !== want.group_last) begin
                        fails++;
                        $display("%0t: group_last mismatch, expected %b, actual %b",
                                 $time, want.group_last, i_m_tuser);
                    end
                    if (i_m_tlast !== want.message_last) begin
                        fails++;
                        $display("%0t: message_last mismatch, expected %b, actual %b",
                                 $time, want.message_last, i_m_tlast);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_symbols.size();
    end

endmodule

/* sim/byte_to_base32_symbol_encoder_tb.sv */
`timescale 1ns / 1ps
module byte_to_base32_symbol_encoder_tb;
    import b32e_pkg::*;

    localparam int RANDOM_WORDS = 500;
    localparam int PHASE_WORDS  = 175;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic                   i_clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int tx_idle_pct  = 14;
    int rx_idle_pct  = 77;
    int fail_count;
    int pending_count;
    int quiet_cycles = 0;
    int words_sent   = 0;
    int directed_words;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    byte_to_base32_symbol_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    byte_to_base32_symbol_encoder_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        if (words_sent < PHASE_WORDS) begin
            tx_idle_pct = 14;
            rx_idle_pct = 77;
        end else if (words_sent < 2 * PHASE_WORDS) begin
            tx_idle_pct = 77;
            rx_idle_pct = 14;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'(b);
        s_tlast  <= msg_end;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic send_message(input int len, input logic closed);
        int i;
        for (i = 0; i < len; i++) begin
            send_byte(BYTE_W'($urandom_range(255)), closed && (i == len - 1));
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // end mark on the first, second and third byte of a group
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // two full groups without an end mark, then groups closed on their second or third byte
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        directed_words = words_sent;

        // mostly closed messages, some open runs that only form groups of three
        while (words_sent < directed_words + RANDOM_WORDS) begin
            if ($urandom_range(9) < 8) begin
                send_message($urandom_range(1, 8), 1'b1);
            end else begin
                send_message($urandom_range(1, 4), 1'b0);
            end
        end
        send_byte(8'h5A, 1'b1);
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/b32e_pkg.sv
design/b32e_front.sv
design/b32e_queue.sv
design/b32e_back.sv
design/byte_to_base32_symbol_encoder.sv
sim/byte_to_base32_symbol_encoder_chk.sv
sim/byte_to_base32_symbol_encoder_tb.sv
